FILE: rtl/axis_angle_rotation_matrix_macros.svh
// ============================================================================
// Assertion macros for the axis-angle rotation matrix block
// Shared concurrent property wrappers, clocked and disabled in reset.
// ============================================================================
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH

// same-cycle implication
`define AARM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aarm: implication failed");

// implication after a fixed delay
`define AARM_ASSERT_LAT(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("aarm: delayed implication failed");

`endif

FILE: rtl/aarm_pkg.sv
// ============================================================================
// aarm_pkg
// Widths, constants, stage indexes and helpers of the rotation matrix block.
// ============================================================================
package aarm_pkg;

    localparam int ANGLE_BITS      = 16;
    localparam int ENTRY_FRAC_BITS = 14;
    localparam int ENTRY_W         = ENTRY_FRAC_BITS + 2;
    localparam int AXIS_W          = 16;

    localparam logic signed [ENTRY_W-1:0] ONE_ENTRY =
        ENTRY_W'(64'd1 << ENTRY_FRAC_BITS);

    // Q.30 constants
    localparam logic [31:0] ONE30       = 32'h4000_0000;
    localparam logic [31:0] HALF_PI_Q30 = 32'h6487_ED51;

    // series terms of sin and cos
    localparam int SC_TERMS = 9;
    // theta, t2, three stages per term, clamp/quadrant
    localparam int SC_LAT   = 3 * SC_TERMS + 3;

    // normalizer widths
    localparam int L2S_W  = 62;
    localparam int ROOT_W = 31;

    // absolute register stage indexes of the top level
    localparam int IDX_SQ  = 3;
    localparam int IDX_DF  = IDX_SQ + ROOT_W + 1;
    localparam int IDX_N   = IDX_DF + ROOT_W + 1;
    localparam int TOP_LAT = IDX_N + 4;
    localparam int SC_DLY  = IDX_N - SC_LAT;

    // rounding shift from Q.60 to the entry format
    localparam int ENTRY_RS = 60 - ENTRY_FRAC_BITS;

    typedef struct packed {
        logic [4:0]             h;
        logic [2:0][AXIS_W-1:0] mag;
        logic [2:0]             neg;
        logic                   zero;
    } side_t;

    typedef struct packed {
        logic signed [31:0] sn;
        logic signed [31:0] cs;
    } sc_t;

    typedef struct packed {
        logic [31:0]        t2;
        logic [1:0]         quad;
        logic signed [33:0] s;
        logic signed [33:0] c;
    } sc_carry_t;

    // round half up from Q.60, then saturate to plus or minus one
    function automatic logic signed [ENTRY_W-1:0] finish_entry(logic signed [63:0] acc);
        logic signed [63:0] v;
        v = (acc + (64'sd1 <<< (ENTRY_RS - 1))) >>> ENTRY_RS;
        if (v > (64'sd1 <<< ENTRY_FRAC_BITS))
        begin
            v = 64'sd1 <<< ENTRY_FRAC_BITS;
        end
        else if (v < -(64'sd1 <<< ENTRY_FRAC_BITS))
        begin
            v = -(64'sd1 <<< ENTRY_FRAC_BITS);
        end
        return ENTRY_W'(v);
    endfunction

    // clamp a series sum to [0, one]
    function automatic logic signed [31:0] clamp01(logic signed [33:0] v);
        logic signed [31:0] r;
        if (v < 34'sd0)
        begin
            r = 32'sd0;
        end
        else if (v > $signed({2'b00, ONE30}))
        begin
            r = $signed(ONE30);
        end
        else
        begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage

FILE: rtl/aarm_sincos.sv
// ============================================================================
// aarm_sincos
// Pipelined Taylor-series sine and cosine of a turn fraction, Q.30 results.
// ============================================================================
module aarm_sincos
    import aarm_pkg::*;
(
    input  logic                  clk,
    input  logic [ANGLE_BITS-1:0] turn_angle,
    output sc_t                   sc
);

    logic [31:0] phase;
    logic [63:0] th_prod;
    logic [31:0] th_next;
    logic [31:0] th_reg;
    logic [1:0]  quad0_reg;
    logic [63:0] t2_prod;

    // term outputs, index 0 is the series start
    logic [31:0] ts_reg [0:SC_TERMS];
    logic [31:0] tc_reg [0:SC_TERMS];
    sc_carry_t   cr_reg [0:SC_TERMS];

    // product stage
    logic [63:0] pa_s_reg [1:SC_TERMS];
    logic [63:0] pa_c_reg [1:SC_TERMS];
    sc_carry_t   ca_reg   [1:SC_TERMS];

    // reciprocal stage
    logic [31:0] xb_s_reg [1:SC_TERMS];
    logic [31:0] xb_c_reg [1:SC_TERMS];
    logic [63:0] mb_s_reg [1:SC_TERMS];
    logic [63:0] mb_c_reg [1:SC_TERMS];
    sc_carry_t   cb_reg   [1:SC_TERMS];

    sc_t         sc_reg;

    // theta in Q.30 radians within the quadrant
    always_comb
    begin
        phase   = 32'(turn_angle) << (32 - ANGLE_BITS);
        th_prod = 64'(phase[29:0]) * 64'(HALF_PI_Q30) + (64'd1 << 29);
        th_next = 32'(th_prod >> 30);
        t2_prod = 64'(th_reg) * 64'(th_reg) + (64'd1 << 29);
    end

    always_ff @(posedge clk)
    begin
        th_reg    <= th_next;
        quad0_reg <= phase[31:30];
    end

    // series start: theta squared
    always_ff @(posedge clk)
    begin
        ts_reg[0]      <= th_reg;
        tc_reg[0]      <= ONE30;
        cr_reg[0].t2   <= 32'(t2_prod >> 30);
        cr_reg[0].quad <= quad0_reg;
        cr_reg[0].s    <= $signed(34'(th_reg));
        cr_reg[0].c    <= $signed(34'(ONE30));
    end

    // one term per three stages
    for (genvar gi = 1; gi <= SC_TERMS; gi++)
    begin : g_term
        localparam logic [63:0] DS = 64'(2 * gi * (2 * gi + 1));
        localparam logic [63:0] DC = 64'((2 * gi - 1) * (2 * gi));
        localparam logic [63:0] MS = (64'd1 << 32) / DS;
        localparam logic [63:0] MC = (64'd1 << 32) / DC;

        logic [31:0] q0_s;
        logic [31:0] q0_c;
        logic [63:0] rem_s;
        logic [63:0] rem_c;
        logic [31:0] q_s;
        logic [31:0] q_c;

        always_ff @(posedge clk)
        begin
            pa_s_reg[gi] <= 64'(ts_reg[gi-1]) * 64'(cr_reg[gi-1].t2);
            pa_c_reg[gi] <= 64'(tc_reg[gi-1]) * 64'(cr_reg[gi-1].t2);
            ca_reg[gi]   <= cr_reg[gi-1];
        end

        always_ff @(posedge clk)
        begin
            xb_s_reg[gi] <= pa_s_reg[gi][61:30];
            xb_c_reg[gi] <= pa_c_reg[gi][61:30];
            mb_s_reg[gi] <= 64'(pa_s_reg[gi][61:30]) * 64'(MS[31:0]);
            mb_c_reg[gi] <= 64'(pa_c_reg[gi][61:30]) * 64'(MC[31:0]);
            cb_reg[gi]   <= ca_reg[gi];
        end

        // quotient estimate is low by at most one
        always_comb
        begin
            q0_s  = mb_s_reg[gi][63:32];
            q0_c  = mb_c_reg[gi][63:32];
            rem_s = 64'(xb_s_reg[gi]) - 64'(q0_s) * DS;
            rem_c = 64'(xb_c_reg[gi]) - 64'(q0_c) * DC;
            q_s   = (rem_s >= DS) ? q0_s + 32'd1 : q0_s;
            q_c   = (rem_c >= DC) ? q0_c + 32'd1 : q0_c;
        end

        always_ff @(posedge clk)
        begin
            ts_reg[gi]      <= q_s;
            tc_reg[gi]      <= q_c;
            cr_reg[gi].t2   <= cb_reg[gi].t2;
            cr_reg[gi].quad <= cb_reg[gi].quad;
            if (gi % 2 == 1)
            begin
                cr_reg[gi].s <= cb_reg[gi].s - $signed(34'(q_s));
                cr_reg[gi].c <= cb_reg[gi].c - $signed(34'(q_c));
            end
            else
            begin
                cr_reg[gi].s <= cb_reg[gi].s + $signed(34'(q_s));
                cr_reg[gi].c <= cb_reg[gi].c + $signed(34'(q_c));
            end
        end
    end

    // clamp and quadrant map
    always_ff @(posedge clk)
    begin
        unique case (cr_reg[SC_TERMS].quad)
            2'd0:
            begin
                sc_reg.sn <= clamp01(cr_reg[SC_TERMS].s);
                sc_reg.cs <= clamp01(cr_reg[SC_TERMS].c);
            end
            2'd1:
            begin
                sc_reg.sn <= clamp01(cr_reg[SC_TERMS].c);
                sc_reg.cs <= -clamp01(cr_reg[SC_TERMS].s);
            end
            2'd2:
            begin
                sc_reg.sn <= -clamp01(cr_reg[SC_TERMS].s);
                sc_reg.cs <= -clamp01(cr_reg[SC_TERMS].c);
            end
            default:
            begin
                sc_reg.sn <= -clamp01(cr_reg[SC_TERMS].c);
                sc_reg.cs <= clamp01(cr_reg[SC_TERMS].s);
            end
        endcase
    end

    assign sc = sc_reg;

endmodule

FILE: rtl/axis_angle_rotation_matrix.sv
// ============================================================================
// axis_angle_rotation_matrix
// Rodrigues rotation matrix from a turn angle and an unnormalized axis.
// ============================================================================
// Usage:
//   Drive turn_angle and axis_x/y/z and pulse start; a beat is taken at each
//   rising edge with start high and busy low. busy stays low: the pipeline
//   takes one beat every cycle.
//   The nine Q1.14 entries m00..m22 and zero_axis appear for one cycle with
//   done high and are taken at the following edge, in order of
//   acceptance.
//   Latency is set by the axis normalizer: a one-bit-per-stage square root
//   (31 stages) followed by three one-bit-per-stage dividers (31 stages).
//   The sine/cosine series runs alongside in 30 stages and is delayed to
//   meet the unit axis. Throughput is one item per cycle.
//   A zero-length axis yields the identity matrix and zero_axis high.
//   Reset clears the valid bits only; no item is in flight after it.
//   The receiver cannot stall: results must be taken when done is high.
// ============================================================================
module axis_angle_rotation_matrix
    import aarm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ANGLE_BITS-1:0]     turn_angle,
    input  logic signed [AXIS_W-1:0]  axis_x,
    input  logic signed [AXIS_W-1:0]  axis_y,
    input  logic signed [AXIS_W-1:0]  axis_z,
    output logic                      done,
    output logic signed [ENTRY_W-1:0] m00,
    output logic signed [ENTRY_W-1:0] m01,
    output logic signed [ENTRY_W-1:0] m02,
    output logic signed [ENTRY_W-1:0] m10,
    output logic signed [ENTRY_W-1:0] m11,
    output logic signed [ENTRY_W-1:0] m12,
    output logic signed [ENTRY_W-1:0] m20,
    output logic signed [ENTRY_W-1:0] m21,
    output logic signed [ENTRY_W-1:0] m22,
    output logic                      zero_axis
);

`include "axis_angle_rotation_matrix_macros.svh"

    logic [TOP_LAT:1] vld_reg;
    side_t            side_reg [1:TOP_LAT-1];
    side_t            side_next;
    side_t            side2_next;

    logic signed [31:0] sqx;
    logic signed [31:0] sqy;
    logic signed [31:0] sqz;
    logic [31:0]        l2_next;
    logic [31:0]        l2_1_reg;
    logic [31:0]        l2_2_reg;
    logic [4:0]         msb;
    logic [5:0]         h_wide;
    logic [L2S_W-1:0]   l2s_next;

    logic [L2S_W-1:0]   sq_v_reg    [0:ROOT_W];
    logic [32:0]        sq_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]  sq_root_reg [0:ROOT_W];

    logic [ROOT_W-1:0]  dv_rem_reg [0:ROOT_W][3];
    logic [ROOT_W-1:0]  dv_low_reg [0:ROOT_W][3];
    logic [ROOT_W-1:0]  dv_q_reg   [0:ROOT_W][3];
    logic [ROOT_W-1:0]  dv_r_reg   [0:ROOT_W];

    logic signed [31:0] n_reg [3];

    sc_t                sc;
    sc_t                sc_dly_reg [1:SC_DLY];

    logic signed [63:0] pp_reg  [6];
    logic signed [63:0] cr_reg  [3];
    logic signed [31:0] cs1_reg;
    logic signed [32:0] omc_reg;
    logic signed [63:0] omp_reg [6];
    logic signed [63:0] cr2_reg [3];
    logic signed [31:0] cs2_reg;
    logic signed [63:0] acc_reg [9];
    logic signed [ENTRY_W-1:0] m_reg [9];
    logic               zero_reg;

    assign busy = 1'b0;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[TOP_LAT-1:1], start & ~busy};
        end
    end

    // stage 1: squared length and magnitudes
    always_comb
    begin
        sqx     = axis_x * axis_x;
        sqy     = axis_y * axis_y;
        sqz     = axis_z * axis_z;
        l2_next = 32'(sqx) + 32'(sqy) + 32'(sqz);
        side_next.h      = 5'd0;
        side_next.neg    = {axis_z[AXIS_W-1], axis_y[AXIS_W-1], axis_x[AXIS_W-1]};
        side_next.mag[0] = axis_x[AXIS_W-1] ? AXIS_W'(-axis_x) : axis_x;
        side_next.mag[1] = axis_y[AXIS_W-1] ? AXIS_W'(-axis_y) : axis_y;
        side_next.mag[2] = axis_z[AXIS_W-1] ? AXIS_W'(-axis_z) : axis_z;
        side_next.zero   = (l2_next == 32'd0);
    end

    // stage 2: leading one of the length, even shift count
    always_comb
    begin
        msb = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (l2_1_reg[i])
            begin
                msb = 5'(i);
            end
        end
        h_wide       = (6'd61 - 6'(msb)) >> 1;
        side2_next   = side_reg[1];
        side2_next.h = h_wide[4:0];
        l2s_next     = L2S_W'(l2_2_reg) << (2 * side_reg[2].h);
    end

    always_ff @(posedge clk)
    begin
        l2_1_reg    <= l2_next;
        l2_2_reg    <= l2_1_reg;
        side_reg[1] <= side_next;
        side_reg[2] <= side2_next;
        for (int t = 3; t < TOP_LAT; t++)
        begin
            side_reg[t] <= side_reg[t-1];
        end
    end

    // stage 3: normalized length enters the root pipe
    always_ff @(posedge clk)
    begin
        sq_v_reg[0]    <= l2s_next;
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
    end

    // square root, one root bit per stage
    for (genvar gs = 1; gs <= ROOT_W; gs++)
    begin : g_sqrt
        logic [34:0] r2;
        logic [34:0] trial;

        always_comb
        begin
            r2    = {sq_rem_reg[gs-1], sq_v_reg[gs-1][L2S_W-1:L2S_W-2]};
            trial = 35'({sq_root_reg[gs-1], 2'b01});
        end

        always_ff @(posedge clk)
        begin
            sq_v_reg[gs] <= sq_v_reg[gs-1] << 2;
            if (r2 >= trial)
            begin
                sq_rem_reg[gs]  <= 33'(r2 - trial);
                sq_root_reg[gs] <= {sq_root_reg[gs-1][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg[gs]  <= r2[32:0];
                sq_root_reg[gs] <= {sq_root_reg[gs-1][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // dividend forming: |a| * 2^(30+h) plus half the root
    always_ff @(posedge clk)
    begin
        logic [L2S_W-1:0] dvd;
        for (int l = 0; l < 3; l++)
        begin
            dvd = (L2S_W'(side_reg[IDX_DF-1].mag[l]) << (6'd30 + 6'(side_reg[IDX_DF-1].h)))
                + L2S_W'(sq_root_reg[ROOT_W] >> 1);
            dv_rem_reg[0][l] <= dvd[L2S_W-1:ROOT_W];
            dv_low_reg[0][l] <= dvd[ROOT_W-1:0];
            dv_q_reg[0][l]   <= '0;
        end
        dv_r_reg[0] <= sq_root_reg[ROOT_W];
    end

    // restoring division, one quotient bit per stage, three lanes
    for (genvar gd = 1; gd <= ROOT_W; gd++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            logic [ROOT_W:0] r2;
            for (int l = 0; l < 3; l++)
            begin
                r2 = {dv_rem_reg[gd-1][l], dv_low_reg[gd-1][l][ROOT_W-1]};
                dv_low_reg[gd][l] <= dv_low_reg[gd-1][l] << 1;
                if (r2 >= {1'b0, dv_r_reg[gd-1]})
                begin
                    dv_rem_reg[gd][l] <= ROOT_W'(r2 - {1'b0, dv_r_reg[gd-1]});
                    dv_q_reg[gd][l]   <= {dv_q_reg[gd-1][l][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_reg[gd][l] <= r2[ROOT_W-1:0];
                    dv_q_reg[gd][l]   <= {dv_q_reg[gd-1][l][ROOT_W-2:0], 1'b0};
                end
            end
            dv_r_reg[gd] <= dv_r_reg[gd-1];
        end
    end

    // unit axis: clamp to one and restore sign
    always_ff @(posedge clk)
    begin
        logic [31:0] q;
        for (int l = 0; l < 3; l++)
        begin
            q = 32'(dv_q_reg[ROOT_W][l]);
            if (q > ONE30)
            begin
                q = ONE30;
            end
            n_reg[l] <= side_reg[IDX_N-1].neg[l] ? -$signed(q) : $signed(q);
        end
    end

    // sine and cosine, aligned to the unit axis
    aarm_sincos u_sincos
    (
        .clk        (clk),
        .turn_angle (turn_angle),
        .sc         (sc)
    );

    always_ff @(posedge clk)
    begin
        sc_dly_reg[1] <= sc;
        for (int t = 2; t <= SC_DLY; t++)
        begin
            sc_dly_reg[t] <= sc_dly_reg[t-1];
        end
    end

    // E1: axis outer products and cross terms
    always_ff @(posedge clk)
    begin
        pp_reg[0] <= n_reg[0] * n_reg[0];
        pp_reg[1] <= n_reg[1] * n_reg[1];
        pp_reg[2] <= n_reg[2] * n_reg[2];
        pp_reg[3] <= n_reg[0] * n_reg[1];
        pp_reg[4] <= n_reg[0] * n_reg[2];
        pp_reg[5] <= n_reg[1] * n_reg[2];
        for (int k = 0; k < 3; k++)
        begin
            cr_reg[k] <= sc_dly_reg[SC_DLY].sn * n_reg[k];
        end
        cs1_reg <= sc_dly_reg[SC_DLY].cs;
        omc_reg <= $signed(33'(ONE30)) - 33'(sc_dly_reg[SC_DLY].cs);
    end

    // E2: round products to Q.30, scale by one minus cosine
    always_ff @(posedge clk)
    begin
        logic signed [31:0] p;
        for (int q = 0; q < 6; q++)
        begin
            p = 32'((pp_reg[q] + (64'sd1 <<< 29)) >>> 30);
            omp_reg[q] <= omc_reg * p;
        end
        cr2_reg <= cr_reg;
        cs2_reg <= cs1_reg;
    end

    // E3: entry sums in Q.60
    always_ff @(posedge clk)
    begin
        acc_reg[0] <= omp_reg[0] + (64'(cs2_reg) <<< 30);
        acc_reg[1] <= omp_reg[3] - cr2_reg[2];
        acc_reg[2] <= omp_reg[4] + cr2_reg[1];
        acc_reg[3] <= omp_reg[3] + cr2_reg[2];
        acc_reg[4] <= omp_reg[1] + (64'(cs2_reg) <<< 30);
        acc_reg[5] <= omp_reg[5] - cr2_reg[0];
        acc_reg[6] <= omp_reg[4] - cr2_reg[1];
        acc_reg[7] <= omp_reg[5] + cr2_reg[0];
        acc_reg[8] <= omp_reg[2] + (64'(cs2_reg) <<< 30);
    end

    // E4: round, saturate, identity for a zero axis
    always_ff @(posedge clk)
    begin
        for (int e = 0; e < 9; e++)
        begin
            if (side_reg[TOP_LAT-1].zero)
            begin
                m_reg[e] <= (e % 4 == 0) ? ONE_ENTRY : '0;
            end
            else
            begin
                m_reg[e] <= finish_entry(acc_reg[e]);
            end
        end
        zero_reg <= side_reg[TOP_LAT-1].zero;
    end

    assign done      = vld_reg[TOP_LAT];
    assign zero_axis = zero_reg;
    assign m00       = m_reg[0];
    assign m01       = m_reg[1];
    assign m02       = m_reg[2];
    assign m10       = m_reg[3];
    assign m11       = m_reg[4];
    assign m12       = m_reg[5];
    assign m20       = m_reg[6];
    assign m21       = m_reg[7];
    assign m22       = m_reg[8];

    // checks
    `AARM_ASSERT_LAT(a_latency, clk, rst_n, start && !busy, TOP_LAT, done)
    `AARM_ASSERT_IMP(a_origin, clk, rst_n, done, $past(start, TOP_LAT))
    `AARM_ASSERT_IMP(a_zero_ident, clk, rst_n, done && zero_axis, m00 == ONE_ENTRY && m01 == '0 && m22 == ONE_ENTRY)
    `AARM_ASSERT_IMP(a_sat, clk, rst_n, done, m11 <= ONE_ENTRY && m11 >= -ONE_ENTRY)

endmodule
